[hdl/tanimoto_descriptor_distance_core_macros.svh]
// Assertion helpers shared by the RTL files.
// Each check is sampled on the rising edge of clock and is switched off while reset is high.
`ifndef TANIMOTO_DESCRIPTOR_DISTANCE_CORE_MACROS_SVH
`define TANIMOTO_DESCRIPTOR_DISTANCE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TDD_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define TDD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define TDD_ASSERT(label, expr, msg)
`define TDD_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

[hdl/tdd_pkg.sv]
`default_nettype none

package tdd_pkg;

   // longest vector that is accumulated
   localparam int unsigned MAX_LEN     = 256;
   // pair counter saturates at MAX_LEN + 1
   localparam int unsigned CNT_W       = $clog2(MAX_LEN + 2);
   localparam int unsigned SUM_W       = $clog2(255 * MAX_LEN + 1);
   localparam int unsigned SQ_W        = $clog2(65025 * MAX_LEN + 1);
   // multiplier operands: x up to a product of two sums, y up to a square sum
   localparam int unsigned X_W         = 2 * SUM_W;
   localparam int unsigned DIG_N       = (SQ_W + 7) / 8;
   localparam int unsigned Y_W         = 8 * DIG_N;
   localparam int unsigned PROD_W      = X_W + Y_W;
   localparam int unsigned D_W         = PROD_W + 1;
   localparam int unsigned DIST_W      = 23;
   localparam int unsigned DIV_STEPS   = 23;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [DIST_W-1:0] FULL_SCALE = DIST_W'(6553600);

   typedef struct packed {
      logic [7:0] elem_a;
      logic [7:0] elem_b;
      logic       last_elem;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance_q16;
      logic              zero_sum;
      logic              too_long;
   } rsp_type;

   // finished sums of one vector pair
   typedef struct packed {
      logic [SUM_W-1:0] sum_a;
      logic [SUM_W-1:0] sum_b;
      logic [SQ_W-1:0]  dot;
      logic [SQ_W-1:0]  sq_a;
      logic [SQ_W-1:0]  sq_b;
      logic             too_long;
   } sums_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

[hdl/tdd_front.sv]
`default_nettype none

module tdd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tdd_pkg::req_type      req_data,
   input  tdd_pkg::q_status_type q_status,
   output logic                  push,
   output tdd_pkg::sums_type     push_data
);
   import tdd_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [SQ_W-1:0]  dot_ff, dot_in, sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   logic             take;
   logic             accept;
   logic [15:0]      p_ab, p_aa, p_bb;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      take     = count_ff < CNT_W'(MAX_LEN);
      p_ab     = 16'(req_data.elem_a) * 16'(req_data.elem_b);
      p_aa     = 16'(req_data.elem_a) * 16'(req_data.elem_a);
      p_bb     = 16'(req_data.elem_b) * 16'(req_data.elem_b);
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      dot_in   = dot_ff;
      sq_a_in  = sq_a_ff;
      sq_b_in  = sq_b_ff;
      if (take) begin
         sum_a_in = sum_a_ff + SUM_W'(req_data.elem_a);
         sum_b_in = sum_b_ff + SUM_W'(req_data.elem_b);
         dot_in   = dot_ff + SQ_W'(p_ab);
         sq_a_in  = sq_a_ff + SQ_W'(p_aa);
         sq_b_in  = sq_b_ff + SQ_W'(p_bb);
      end
      count_in = (count_ff <= CNT_W'(MAX_LEN)) ? count_ff + 1'b1 : count_ff;

      push               = accept && req_data.last_elem;
      push_data.sum_a    = sum_a_in;
      push_data.sum_b    = sum_b_in;
      push_data.dot      = dot_in;
      push_data.sq_a     = sq_a_in;
      push_data.sq_b     = sq_b_in;
      push_data.too_long = count_in > CNT_W'(MAX_LEN);
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         dot_ff   <= '0;
         sq_a_ff  <= '0;
         sq_b_ff  <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         dot_ff   <= dot_in;
         sq_a_ff  <= sq_a_in;
         sq_b_ff  <= sq_b_in;
      end
   end

endmodule

`default_nettype wire

[hdl/tdd_queue.sv]
`default_nettype none
`include "tanimoto_descriptor_distance_core_macros.svh"

module tdd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tdd_pkg::sums_type     push_data,
   input  logic                  pop,
   output tdd_pkg::sums_type     pop_data,
   output tdd_pkg::q_status_type status
);
   import tdd_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QC_W  = $clog2(QUEUE_DEPTH + 1);

   sums_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QC_W-1:0]   count_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign pop_data     = slots_ff[rd_ptr_ff];
   assign status.full  = count_ff == QC_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `TDD_ASSERT_IMP(a_no_overflow, push, count_ff < QC_W'(QUEUE_DEPTH), "push into full queue")
   `TDD_ASSERT_IMP(a_no_underflow, pop, count_ff != '0, "pop from empty queue")
   `TDD_ASSERT(a_count_range, count_ff <= QC_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

[hdl/tdd_back.sv]
`default_nettype none
`include "tanimoto_descriptor_distance_core_macros.svh"

module tdd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tdd_pkg::q_status_type q_status,
   input  tdd_pkg::sums_type     pop_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tdd_pkg::rsp_type      rsp_data
);
   import tdd_pkg::*;

   localparam int unsigned DIG_W  = (DIG_N > 1) ? $clog2(DIG_N) : 1;
   localparam int unsigned STEP_W = $clog2(DIV_STEPS);
   localparam int unsigned E_W    = D_W + 7;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_ADD, S_SUB, S_SUB2, S_SCALE1, S_SCALE2, S_DIV, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_AB, OP_BB, OP_AA, OP_N, OP_T1, OP_T2
   } op_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [DIG_W-1:0]  dig_ff, dig_in;
   logic [SUM_W-1:0]  sa_ff, sa_in, sb_ff, sb_in;
   logic [SQ_W-1:0]   sab_ff, sab_in, saa_ff, saa_in, sbb_ff, sbb_in;
   logic              long_ff, long_in, zero_ff, zero_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [Y_W-1:0]    y_ff, y_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [X_W-1:0]    m_ab_ff, m_ab_in, m_bb_ff, m_bb_in, m_aa_ff, m_aa_in;
   logic [PROD_W-1:0] n_ff, n_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [D_W-1:0]    s_ff, s_in, d_ff, d_in, e_ff, e_in, rem_ff, rem_in;
   logic [E_W-1:0]    e96_ff, e96_in;
   logic [DIV_STEPS-1:0] lo_ff, lo_in;
   logic [DIST_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [7:0]        digit;
   logic [X_W+7:0]    part;
   logic [PROD_W-1:0] acc_next;
   logic [E_W-1:0]    e100;
   logic [D_W:0]      trial;

   assign pop       = (state_ff == S_IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      digit    = y_ff[Y_W-1 -: 8];
      part     = (X_W + 8)'(x_ff) * (X_W + 8)'(digit);
      acc_next = (acc_ff << 8) + PROD_W'(part);
      e100     = e96_ff + (E_W'(e_ff) << 2);
      trial    = {rem_ff, lo_ff[DIV_STEPS-1]};

      state_in     = state_ff;
      op_in        = op_ff;
      dig_in       = dig_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      sab_in       = sab_ff;
      saa_in       = saa_ff;
      sbb_in       = sbb_ff;
      long_in      = long_ff;
      zero_in      = zero_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      m_ab_in      = m_ab_ff;
      m_bb_in      = m_bb_ff;
      m_aa_in      = m_aa_ff;
      n_in         = n_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      s_in         = s_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      e96_in       = e96_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               sa_in   = pop_data.sum_a;
               sb_in   = pop_data.sum_b;
               sab_in  = pop_data.dot;
               saa_in  = pop_data.sq_a;
               sbb_in  = pop_data.sq_b;
               long_in = pop_data.too_long;
               zero_in = (pop_data.sum_a == '0) || (pop_data.sum_b == '0);
               op_in   = OP_AB;
               dig_in  = '0;
               acc_in  = '0;
               x_in    = X_W'(pop_data.sum_a);
               y_in    = Y_W'(pop_data.sum_b);
               q_in    = '0;
               state_in = zero_in ? S_DONE : S_MUL;
            end
         end
         S_MUL: begin
            // one byte of y per cycle, most significant first
            acc_in = acc_next;
            y_in   = y_ff << 8;
            dig_in = dig_ff + 1'b1;
            if (dig_ff == DIG_W'(DIG_N - 1)) begin
               acc_in = '0;
               dig_in = '0;
               case (op_ff)
                  OP_AB: begin
                     m_ab_in = acc_next[X_W-1:0];
                     op_in   = OP_BB;
                     x_in    = X_W'(sb_ff);
                     y_in    = Y_W'(sb_ff);
                  end
                  OP_BB: begin
                     m_bb_in = acc_next[X_W-1:0];
                     op_in   = OP_AA;
                     x_in    = X_W'(sa_ff);
                     y_in    = Y_W'(sa_ff);
                  end
                  OP_AA: begin
                     m_aa_in = acc_next[X_W-1:0];
                     op_in   = OP_N;
                     x_in    = m_ab_ff;
                     y_in    = Y_W'(sab_ff);
                  end
                  OP_N: begin
                     n_in  = acc_next;
                     op_in = OP_T1;
                     x_in  = m_bb_ff;
                     y_in  = Y_W'(saa_ff);
                  end
                  OP_T1: begin
                     t1_in = acc_next;
                     op_in = OP_T2;
                     x_in  = m_aa_ff;
                     y_in  = Y_W'(sbb_ff);
                  end
                  OP_T2: begin
                     t2_in    = acc_next;
                     state_in = S_ADD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD: begin
            s_in     = D_W'(t1_ff) + D_W'(t2_ff);
            state_in = S_SUB;
         end
         S_SUB: begin
            d_in     = s_ff - D_W'(n_ff);
            state_in = S_SUB2;
         end
         S_SUB2: begin
            e_in = d_ff - D_W'(n_ff);
            if (d_ff == '0) begin
               q_in     = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_SCALE1;
            end
         end
         S_SCALE1: begin
            e96_in   = (E_W'(e_ff) << 6) + (E_W'(e_ff) << 5);
            state_in = S_SCALE2;
         end
         S_SCALE2: begin
            // numerator is e * 100 * 2^16; the part above bit 23 is below d
            rem_in   = e100[E_W-1:7];
            lo_in    = {e100[6:0], 16'h0000};
            q_in     = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            lo_in   = lo_ff << 1;
            step_in = step_ff + 1'b1;
            if (trial >= {1'b0, d_ff}) begin
               rem_in = D_W'(trial - {1'b0, d_ff});
               q_in   = {q_ff[DIST_W-2:0], 1'b1};
            end else begin
               rem_in = trial[D_W-1:0];
               q_in   = {q_ff[DIST_W-2:0], 1'b0};
            end
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.distance_q16 = (q_ff > FULL_SCALE) ? FULL_SCALE : q_ff;
               rsp_in.zero_sum     = zero_ff;
               rsp_in.too_long     = long_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      dig_ff  <= dig_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      sab_ff  <= sab_in;
      saa_ff  <= saa_in;
      sbb_ff  <= sbb_in;
      long_ff <= long_in;
      zero_ff <= zero_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      m_ab_ff <= m_ab_in;
      m_bb_ff <= m_bb_in;
      m_aa_ff <= m_aa_in;
      n_ff    <= n_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      s_ff    <= s_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      e96_ff  <= e96_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   `TDD_ASSERT_IMP(a_dist_range, rsp_valid_ff, rsp_ff.distance_q16 <= FULL_SCALE,
                   "distance above full scale")
   `TDD_ASSERT_IMP(a_zero_dist, rsp_valid_ff && rsp_ff.zero_sum, rsp_ff.distance_q16 == '0,
                   "zero sum with nonzero distance")
   `TDD_ASSERT_IMP(a_div_nonzero, state_ff == S_DIV, d_ff != '0, "division by zero divisor")

endmodule

`default_nettype wire

[hdl/tanimoto_descriptor_distance_core.sv]
// Tanimoto distance core: element pairs are taken one per cycle when the sum queue has room.
// From the transfer of the last pair, the sums pass through the byte-serial multiplier and the
// 23-step divider before rsp_valid; a zero sum skips both and goes straight to the result.
// The back end takes one vector pair at a time; a two-entry sum queue absorbs short vectors.
// Reset is synchronous and active high: it clears the accumulators, the queue and rsp_valid.
`default_nettype none

module tanimoto_descriptor_distance_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tdd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tdd_pkg::rsp_type rsp_data
);
   import tdd_pkg::*;

   // front end -> queue
   logic         push;
   sums_type     push_data;
   // queue -> back end
   logic         pop;
   sums_type     pop_data;
   q_status_type q_status;

   // Front end: three products and two bytes per transfer feed five running sums and a saturating
   // pair count. Pairs beyond MAX_LEN are counted but not summed. On the last pair the
   // finished sums go into the queue and the accumulators clear in the same cycle.
   tdd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // Short queue so the front end keeps streaming while the back end divides.
   tdd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // Back end: N = Sab*SA*SB, D = Saa*SB^2 + Sbb*SA^2 - N through one shared
   // byte-serial multiplier, then floor(6553600*(D - N)/D) by restoring division,
   // one quotient bit per cycle. The result sits in an output register.
   tdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[test/tb_tanimoto_descriptor_distance_core.sv]
`default_nettype none

module tb_tanimoto_descriptor_distance_core;

   import tdd_pkg::*;

   // Back-end latency allowance: byte-serial multiply plus the 23-step divide.
   localparam int unsigned LATENCY     = 6 * DIG_N + 30;
   localparam int unsigned CYCLE_LIMIT = 400000;
   // Short-vector budget per idling phase, in element pairs.
   localparam int unsigned PHASE_PAIRS = 135;

   // Intermediate products: an accumulator times two sums, scaled by full scale.
   typedef bit [127:0] wide_t;

   // How the elements of one vector pair are filled.
   typedef enum int {
      FILL_RANDOM,
      FILL_SAME,
      FILL_SCALED,
      FILL_DISJOINT,
      FILL_ZERO_A,
      FILL_ZERO_B,
      FILL_FULL,
      FILL_SPARSE
   } fill_mode_t;

   // One pending element pair together with the idling that applies while it is sent.
   typedef struct {
      req_type     pair;
      int unsigned idle_pct;
      int unsigned stall_pct;
      bit          drain;
   } stim_item_t;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_item_t pair_q[$];
   rsp_type    distance_q[$];

   // Running sums for the vector pair in progress, at the core's own widths.
   logic [SUM_W-1:0] acc_sum_a;
   logic [SUM_W-1:0] acc_sum_b;
   logic [SQ_W-1:0]  acc_dot;
   logic [SQ_W-1:0]  acc_sq_a;
   logic [SQ_W-1:0]  acc_sq_b;
   logic [CNT_W-1:0] pairs_seen;

   int unsigned send_idle    = 0;
   int unsigned recv_stall   = 0;
   int unsigned stall_pct    = 0;
   bit          hold_next    = 1'b0;
   int unsigned pairs_queued = 0;
   int unsigned cycle_count  = 0;
   int unsigned errors       = 0;
   bit          req_taken    = 1'b0;

   tanimoto_descriptor_distance_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Folds one element pair into the running sums. On the last pair it works out the
   // distance exactly as floor(6553600 * (D - N) / D), with N = Sab*SA*SB and
   // D = Saa*SB^2 + Sbb*SA^2 - N, then clears the sums. Returns 1 when a result is due.
   function automatic bit fold_pair(input req_type p, output rsp_type r);
      wide_t n;
      wide_t d;
      wide_t q;
      r = '0;
      // pairs beyond MAX_LEN are counted but not summed; the counter saturates
      if (pairs_seen < MAX_LEN) begin
         acc_sum_a += p.elem_a;
         acc_sum_b += p.elem_b;
         acc_dot   += p.elem_a * p.elem_b;
         acc_sq_a  += p.elem_a * p.elem_a;
         acc_sq_b  += p.elem_b * p.elem_b;
      end
      if (pairs_seen <= MAX_LEN)
         pairs_seen++;
      if (!p.last_elem)
         return 1'b0;
      r.too_long = (pairs_seen > MAX_LEN);
      if (acc_sum_a == '0 || acc_sum_b == '0) begin
         r.zero_sum = 1'b1;
      end else begin
         n = wide_t'(acc_dot) * wide_t'(acc_sum_a) * wide_t'(acc_sum_b);
         d = wide_t'(acc_sq_a) * wide_t'(acc_sum_b) * wide_t'(acc_sum_b)
           + wide_t'(acc_sq_b) * wide_t'(acc_sum_a) * wide_t'(acc_sum_a) - n;
         // a zero divisor cannot happen with both sums nonzero; distance stays 0 if it did
         if (d != '0) begin
            q = ((d - n) * wide_t'(FULL_SCALE)) / d;
            if (q > wide_t'(FULL_SCALE))
               q = wide_t'(FULL_SCALE);
            r.distance_q16 = q[DIST_W-1:0];
         end
      end
      acc_sum_a  = '0;
      acc_sum_b  = '0;
      acc_dot    = '0;
      acc_sq_a   = '0;
      acc_sq_b   = '0;
      pairs_seen = '0;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Byte with the extremes well represented.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic fill_mode_t pick_mode();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return FILL_RANDOM;
      if (r < 50) return FILL_SAME;
      if (r < 60) return FILL_SCALED;
      if (r < 70) return FILL_DISJOINT;
      if (r < 75) return FILL_ZERO_A;
      if (r < 80) return FILL_ZERO_B;
      if (r < 85) return FILL_FULL;
      return FILL_SPARSE;
   endfunction

   // Mostly short vectors so that results come often; now and then a longer one.
   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(6, 1);
      if (r < 97) return $urandom_range(32, 7);
      return $urandom_range(128, 33);
   endfunction

   // New idling settings; the first pair sent under them waits for every result.
   task automatic start_phase(input int unsigned idle, input int unsigned stall);
      send_idle  = idle;
      recv_stall = stall;
      hold_next  = 1'b1;
   endtask

   task automatic queue_pair(input logic [7:0] a, input logic [7:0] b, input bit last);
      stim_item_t it;
      it.pair.elem_a    = a;
      it.pair.elem_b    = b;
      it.pair.last_elem = last;
      it.idle_pct       = send_idle;
      it.stall_pct      = recv_stall;
      it.drain          = hold_next;
      hold_next         = 1'b0;
      pair_q.push_back(it);
      pairs_queued++;
   endtask

   task automatic queue_vector(input int unsigned len, input fill_mode_t mode);
      logic [7:0] a;
      logic [7:0] b;
      for (int unsigned i = 0; i < len; i++) begin
         case (mode)
            FILL_SAME: begin
               a = pick_byte();
               b = a;
            end
            // b exactly twice a: proportional vectors, distance zero
            FILL_SCALED: begin
               a = 8'($urandom_range(127));
               b = a << 1;
            end
            // no common nonzero element: dot product zero, distance full scale
            FILL_DISJOINT: begin
               if ($urandom_range(1) == 0) begin
                  a = pick_byte();
                  b = 8'h00;
               end else begin
                  a = 8'h00;
                  b = pick_byte();
               end
            end
            FILL_ZERO_A: begin
               a = 8'h00;
               b = pick_byte();
            end
            FILL_ZERO_B: begin
               a = pick_byte();
               b = 8'h00;
            end
            FILL_FULL: begin
               a = 8'hFF;
               b = 8'hFF;
            end
            FILL_SPARSE: begin
               a = ($urandom_range(3) == 0) ? pick_byte() : 8'h00;
               b = ($urandom_range(3) == 0) ? pick_byte() : 8'h00;
            end
            default: begin
               a = pick_byte();
               b = pick_byte();
            end
         endcase
         queue_pair(a, b, i == len - 1);
      end
   endtask

   task automatic queue_short_vectors(input int unsigned budget);
      int unsigned stop;
      stop = pairs_queued + budget;
      while (pairs_queued < stop)
         queue_vector(pick_length(), pick_mode());
   endtask

   // ------------------------------------------------------------------
   // Driver: request side and result-side ready, both changed at the falling edge.
   // A new pair is only loaded once the previous transfer has completed, so valid is
   // never dropped with a pair pending. Each signal gets one assignment per edge.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive
      stim_item_t head;
      bit         send;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            send = 1'b0;
            if (pair_q.size() != 0) begin
               head      = pair_q[0];
               stall_pct = head.stall_pct;
               // a drain point holds the sender back until every result has come
               send = !(head.drain && distance_q.size() != 0)
                      && ($urandom_range(99) >= head.idle_pct);
               if (send) begin
                  req_data <= head.pair;
                  void'(pair_q.pop_front());
               end
            end
            req_valid <= send;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. Accepted pairs feed the
   // predictor; each result transfer is checked against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch
      rsp_type want;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            if (fold_pair(req_data, want))
               distance_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (distance_q.size() == 0) begin
               $error("result transfer with none expected: distance_q16 %0d",
                      rsp_data.distance_q16);
               errors++;
            end else begin
               want = distance_q.pop_front();
               if (rsp_data.distance_q16 !== want.distance_q16) begin
                  $error("distance_q16 mismatch: expected %0d, got %0d",
                         want.distance_q16, rsp_data.distance_q16);
                  errors++;
               end
               if (rsp_data.zero_sum !== want.zero_sum) begin
                  $error("zero_sum mismatch: expected %0b, got %0b",
                         want.zero_sum, rsp_data.zero_sum);
                  errors++;
               end
               if (rsp_data.too_long !== want.too_long) begin
                  $error("too_long mismatch: expected %0b, got %0b",
                         want.too_long, rsp_data.too_long);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on the cycle count.
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("tb_tanimoto_descriptor_distance_core failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sequence: build the whole stimulus, release reset, then wait for the queues to empty.
   // ------------------------------------------------------------------
   initial begin
      acc_sum_a  = '0;
      acc_sum_b  = '0;
      acc_dot    = '0;
      acc_sq_a   = '0;
      acc_sq_b   = '0;
      pairs_seen = '0;

      // Directed part, no idling.
      start_phase(0, 0);
      queue_pair(8'hFF, 8'hFF, 1'b1);          // one pair, identical: distance zero
      queue_pair(8'h00, 8'h00, 1'b1);          // both sums zero
      queue_pair(8'h00, 8'hFF, 1'b1);          // first sum zero
      queue_pair(8'hFF, 8'h00, 1'b1);          // second sum zero
      queue_pair(8'hFF, 8'h00, 1'b0);          // disjoint: full scale
      queue_pair(8'h00, 8'hFF, 1'b1);
      queue_pair(8'h01, 8'hFF, 1'b0);
      queue_pair(8'hFF, 8'h01, 1'b0);
      queue_pair(8'h80, 8'h80, 1'b1);
      queue_pair(8'h01, 8'h02, 1'b0);          // proportional: distance zero
      queue_pair(8'h7F, 8'hFE, 1'b1);
      queue_pair(8'h55, 8'hAA, 1'b0);
      queue_pair(8'hAA, 8'h55, 1'b1);
      queue_pair(8'h00, 8'h00, 1'b0);
      queue_pair(8'h07, 8'h00, 1'b1);
      queue_pair(8'h01, 8'h01, 1'b0);
      queue_pair(8'h00, 8'h00, 1'b1);
      queue_pair(8'hFF, 8'hFE, 1'b0);
      queue_pair(8'h01, 8'h00, 1'b0);
      queue_pair(8'h00, 8'h01, 1'b1);

      // Random part, one phase per idling pattern.
      queue_short_vectors(PHASE_PAIRS);
      start_phase(61, 0);
      queue_short_vectors(PHASE_PAIRS);
      start_phase(0, 61);
      queue_short_vectors(PHASE_PAIRS);
      start_phase(22, 22);
      // exactly MAX_LEN pairs: not too long
      queue_vector(MAX_LEN, FILL_RANDOM);
      // one pair over the limit
      queue_vector(MAX_LEN + 1, pick_mode());
      // first vector zero up to the limit and nonzero after it: the tail is not summed,
      // so zero sum and too long come together
      for (int unsigned i = 0; i < MAX_LEN + 2; i++)
         queue_pair((i < MAX_LEN) ? 8'h00 : 8'($urandom_range(255, 1)), pick_byte(),
                    i == MAX_LEN + 1);
      queue_short_vectors(PHASE_PAIRS);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pair_q.size() != 0 || req_valid)
         @(posedge clock);
      while (distance_q.size() != 0)
         @(posedge clock);
      // let any stray result show itself
      repeat (3 * LATENCY) @(posedge clock);

      if (errors == 0 && distance_q.size() == 0)
         $display("tb_tanimoto_descriptor_distance_core passed");
      else
         $display("tb_tanimoto_descriptor_distance_core failed");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/tdd_pkg.sv
hdl/tdd_front.sv
hdl/tdd_queue.sv
hdl/tdd_back.sv
hdl/tanimoto_descriptor_distance_core.sv
test/tb_tanimoto_descriptor_distance_core.sv
